[design/edd_pkg.sv]
// Shared types and constants for the error diffusion RGB dither.
package edd_pkg;

   localparam int PIX_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int LINE_WIDTH_W = 12;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int BITS_W = 4;
   localparam int DROP_W = 3;

   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;
   localparam logic [BITS_W-1:0] RED_BITS_RST = 4'd5;
   localparam logic [BITS_W-1:0] GREEN_BITS_RST = 4'd6;
   localparam logic [BITS_W-1:0] BLUE_BITS_RST = 4'd5;

   // Errors are never negative: the dropped part is 0..127, so the right
   // share is at most 47, the below-right share at most 31 and a stored
   // next-line entry at most 78.
   localparam int NUM_CH = 3;
   localparam int ERR_W = 7;
   localparam int RIGHT_W = 6;
   localparam int BELOW_W = 5;
   localparam int SUM_W = 9;
   localparam int LINE_ENTRY_W = NUM_CH * ERR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_RED_BITS = 3'd2,
      CSR_GREEN_BITS = 3'd3,
      CSR_BLUE_BITS = 3'd4
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type [NUM_CH];

   // Bits kept per channel, with zero taken as one and above eight as eight,
   // turned into the number of low bits dropped.
   function automatic logic [DROP_W-1:0] drop_bits(input logic [BITS_W-1:0] bits);
      logic [DROP_W-1:0] drop;
      if (bits == '0) begin
         drop = DROP_W'(PIX_W - 1);
      end else if (bits >= BITS_W'(PIX_W)) begin
         drop = '0;
      end else begin
         drop = DROP_W'(BITS_W'(PIX_W) - bits);
      end
      return drop;
   endfunction

endpackage

[design/edd_req_if.sv]
// Request channel carrying one RGB pixel.
interface edd_req_if;
   logic valid;
   logic ready;
   logic [edd_pkg::PIX_W-1:0] red_in;
   logic [edd_pkg::PIX_W-1:0] green_in;
   logic [edd_pkg::PIX_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
endinterface

// Response channel carrying one quantized pixel with its position flags.
interface edd_rsp_if;
   logic valid;
   logic ready;
   logic [edd_pkg::PIX_W-1:0] red_code;
   logic [edd_pkg::PIX_W-1:0] green_code;
   logic [edd_pkg::PIX_W-1:0] blue_code;
   logic end_of_line;
   logic end_of_frame;

   modport source (output valid, output red_code, output green_code, output blue_code,
                   output end_of_line, output end_of_frame, input ready);
   modport sink (input valid, input red_code, input green_code, input blue_code,
                 input end_of_line, input end_of_frame, output ready);
endinterface

[design/error_diffusion_rgb_dither.sv]
// Error diffusion dither of an RGB pixel stream in raster order.
//
// Pixels enter on the request channel in raster order and leave on the
// response channel as quantized codes with end-of-line and end-of-frame flags.
// Line width, frame height and the bits kept per channel are set through the
// csr write port; the user must write them only while the block is idle, as
// the block does not enforce it. A request is registered together with a
// read of the line error memory at its column, and its result is then
// computed into the response register. One request is accepted every cycle
// while the receiver takes responses; the line error memory is read for the
// incoming column and written for the column being finished in the same
// cycle, with the write forwarded when both address the same entry.
// Reset restores the register defaults, returns to the first pixel of a frame
// and marks the stored line errors as empty through a fill count, so no
// clearing pass is needed.
// When the receiver stalls, the response and one pending request are held,
// and the request channel stops accepting until the response is taken.
module error_diffusion_rgb_dither #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic clock,
   input  logic reset,
   edd_req_if.sink req_chan,
   edd_rsp_if.source rsp_chan,
   input  logic csr_write_en,
   input  logic [edd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = (XW + 1 > edd_pkg::LINE_WIDTH_W) ? XW + 1 : edd_pkg::LINE_WIDTH_W;
   localparam int HW = edd_pkg::FRAME_HEIGHT_W;
   localparam int NC = edd_pkg::NUM_CH;
   localparam int EW = edd_pkg::ERR_W;

   logic [edd_pkg::LINE_WIDTH_W-1:0] line_width_ff;
   logic [HW-1:0] frame_height_ff;
   logic [edd_pkg::BITS_W-1:0] red_bits_ff;
   logic [edd_pkg::BITS_W-1:0] green_bits_ff;
   logic [edd_pkg::BITS_W-1:0] blue_bits_ff;

   logic [XW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [XW:0] fill_ff, fill_in;

   logic s1_valid_ff, s1_valid_in;
   edd_pkg::pixel_type s1_pix_ff;
   logic [XW-1:0] s1_col_ff;
   logic s1_eol_ff;
   logic s1_eof_ff;
   logic s1_last_ff;
   logic s1_hit_ff;
   logic [edd_pkg::LINE_ENTRY_W-1:0] s1_err_ff;

   logic [edd_pkg::RIGHT_W-1:0] right_ff [NC];
   logic [edd_pkg::RIGHT_W-1:0] right_in [NC];
   logic [edd_pkg::BELOW_W-1:0] below_ff [NC];
   logic [edd_pkg::BELOW_W-1:0] below_in [NC];

   logic rsp_valid_ff, rsp_valid_in;
   edd_pkg::pixel_type code_ff, code_in;
   logic rsp_eol_ff;
   logic rsp_eof_ff;

   logic [edd_pkg::LINE_ENTRY_W-1:0] line_mem [MAX_WIDTH];
   logic [edd_pkg::LINE_ENTRY_W-1:0] wdata;

   logic accept;
   logic advance;
   logic [WW-1:0] width_raw;
   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_eff;
   logic eol;
   logic last_row;
   logic [edd_pkg::DROP_W-1:0] drop [NC];

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   assign width_raw = WW'(line_width_ff);
   assign width_eff = (width_raw == '0) ? WW'(1) :
                      (width_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_raw;
   assign height_eff = (frame_height_ff == '0) ? HW'(1) : frame_height_ff;
   assign eol = (WW'(col_ff) + WW'(1)) >= width_eff;
   assign last_row = ({1'b0, row_ff} + (HW + 1)'(1)) >= {1'b0, height_eff};

   assign drop[0] = edd_pkg::drop_bits(red_bits_ff);
   assign drop[1] = edd_pkg::drop_bits(green_bits_ff);
   assign drop[2] = edd_pkg::drop_bits(blue_bits_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (eol) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + HW'(1);
            fill_in = {1'b0, col_ff} + (XW + 1)'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_comb begin
      logic [EW-1:0] cur_err;
      logic [edd_pkg::SUM_W-1:0] sum;
      logic [edd_pkg::PIX_W-1:0] clamped;
      logic [edd_pkg::PIX_W-1:0] mask;
      logic [EW-1:0] err;
      logic [EW+2:0] err6;
      logic [edd_pkg::RIGHT_W-1:0] right_share;
      for (int c = 0; c < NC; c++) begin
         cur_err = s1_hit_ff ? s1_err_ff[c*EW +: EW] : '0;
         sum = edd_pkg::SUM_W'(s1_pix_ff[c]) + edd_pkg::SUM_W'(cur_err)
               + edd_pkg::SUM_W'(right_ff[c]);
         clamped = sum[edd_pkg::SUM_W-1] ? '1 : sum[edd_pkg::PIX_W-1:0];
         code_in[c] = clamped >> drop[c];
         mask = (edd_pkg::PIX_W'(1) << drop[c]) - edd_pkg::PIX_W'(1);
         err = EW'(clamped & mask);
         err6 = (EW + 3)'({err, 2'b00}) + (EW + 3)'({err, 1'b0});
         right_share = err6[EW+2:4];
         right_in[c] = s1_eol_ff ? '0 : right_share;
         below_in[c] = (s1_eol_ff || s1_last_ff) ? '0 : err[EW-1:2];
         wdata[c*EW +: EW] = (s1_last_ff ? '0 : EW'(right_share)) + EW'(below_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= edd_pkg::LINE_WIDTH_RST;
         frame_height_ff <= edd_pkg::FRAME_HEIGHT_RST;
         red_bits_ff <= edd_pkg::RED_BITS_RST;
         green_bits_ff <= edd_pkg::GREEN_BITS_RST;
         blue_bits_ff <= edd_pkg::BLUE_BITS_RST;
         col_ff <= '0;
         row_ff <= '0;
         fill_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            right_ff[c] <= '0;
            below_ff[c] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               edd_pkg::CSR_LINE_WIDTH: begin
                  line_width_ff <= csr_wdata[edd_pkg::LINE_WIDTH_W-1:0];
               end
               edd_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata[HW-1:0];
               end
               edd_pkg::CSR_RED_BITS: begin
                  red_bits_ff <= csr_wdata[edd_pkg::BITS_W-1:0];
               end
               edd_pkg::CSR_GREEN_BITS: begin
                  green_bits_ff <= csr_wdata[edd_pkg::BITS_W-1:0];
               end
               edd_pkg::CSR_BLUE_BITS: begin
                  blue_bits_ff <= csr_wdata[edd_pkg::BITS_W-1:0];
               end
               default: begin
               end
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         fill_ff <= fill_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            for (int c = 0; c < NC; c++) begin
               right_ff[c] <= right_in[c];
               below_ff[c] <= below_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff[0] <= req_chan.red_in;
         s1_pix_ff[1] <= req_chan.green_in;
         s1_pix_ff[2] <= req_chan.blue_in;
         s1_col_ff <= col_ff;
         s1_eol_ff <= eol;
         s1_eof_ff <= eol && last_row;
         s1_last_ff <= last_row;
         s1_hit_ff <= {1'b0, col_ff} < fill_ff;
      end
      if (advance) begin
         code_ff <= code_in;
         rsp_eol_ff <= s1_eol_ff;
         rsp_eof_ff <= s1_eof_ff;
      end
   end

   // The entry of a column is read for the incoming pixel and rewritten with
   // the error for the next line once that pixel is finished.
   always_ff @(posedge clock) begin
      if (advance) begin
         line_mem[s1_col_ff] <= wdata;
      end
      if (accept) begin
         if (advance && (s1_col_ff == col_ff)) begin
            s1_err_ff <= wdata;
         end else begin
            s1_err_ff <= line_mem[col_ff];
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red_code = code_ff[0];
   assign rsp_chan.green_code = code_ff[1];
   assign rsp_chan.blue_code = code_ff[2];
   assign rsp_chan.end_of_line = rsp_eol_ff;
   assign rsp_chan.end_of_frame = rsp_eof_ff;

endmodule

[tb/error_diffusion_rgb_dither_tb.sv]
// Self-checking testbench for the error diffusion RGB dither with a built-in predictor.
module error_diffusion_rgb_dither_tb;

   localparam int LINE_MAX = 2048;
   localparam int ERR_LIMIT = 511;
   localparam int RANDOM_PHASES = 8;
   localparam int PIXELS_PER_PHASE = 142;

   typedef struct packed {
      logic [7:0] red_code;
      logic [7:0] green_code;
      logic [7:0] blue_code;
      logic end_of_line;
      logic end_of_frame;
   } dither_out_type;

   typedef enum bit {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      edd_pkg::csr_index_type index;
      logic [15:0] value;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit typed;
      dither_out_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [edd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [edd_pkg::CSR_DATA_W-1:0] csr_wdata;

   edd_req_if req_chan();
   edd_rsp_if rsp_chan();

   error_diffusion_rgb_dither #(.MAX_WIDTH(LINE_MAX)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Predictor state: configuration, per-column errors and raster position.
   int unsigned cfg_width = 640;
   int unsigned cfg_height = 480;
   int unsigned cfg_bits [3] = '{5, 6, 5};
   int line_err_cur [LINE_MAX][3];
   int line_err_next [LINE_MAX][3];
   int carry_err [3];
   int unsigned col_pos;
   int unsigned row_pos;

   dither_out_type expected_codes [$];
   stim_row_type stim_table [$];
   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int pixels_sent;
   int results_seen;
   int lines_seen;
   int frames_seen;
   int config_count;

   function automatic int saturate_error(input int v);
      if (v > ERR_LIMIT) return ERR_LIMIT;
      if (v < -ERR_LIMIT - 1) return -ERR_LIMIT - 1;
      return v;
   endfunction

   function automatic dither_out_type dither_pixel(input logic [7:0] red,
                                                   input logic [7:0] green,
                                                   input logic [7:0] blue);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned kept;
      int unsigned drop;
      int chan_in [3];
      logic [7:0] code [3];
      int v;
      int e;
      bit eol;
      bit last_row;
      dither_out_type res;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > LINE_MAX) w = LINE_MAX;
      h = (cfg_height == 0) ? 1 : cfg_height;
      x = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
      eol = (x + 1 >= w);
      last_row = (row_pos + 1 >= h);
      chan_in[0] = int'(red);
      chan_in[1] = int'(green);
      chan_in[2] = int'(blue);
      for (int c = 0; c < 3; c++) begin
         kept = cfg_bits[c];
         if (kept == 0) kept = 1;
         if (kept > 8) kept = 8;
         drop = 8 - kept;
         v = chan_in[c] + line_err_cur[x][c] + carry_err[c];
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         code[c] = 8'(v >> drop);
         e = v & ((1 << drop) - 1);
         carry_err[c] = eol ? 0 : saturate_error((e * 6) / 16);
         // The below-left share has weight zero and leaves the store unchanged.
         if (!last_row) begin
            line_err_next[x][c] = saturate_error(line_err_next[x][c] + (e * 6) / 16);
            if (!eol && x + 1 < LINE_MAX) begin
               line_err_next[x + 1][c] = saturate_error(line_err_next[x + 1][c] + (e * 4) / 16);
            end
         end
      end
      res.red_code = code[0];
      res.green_code = code[1];
      res.blue_code = code[2];
      res.end_of_line = eol;
      res.end_of_frame = eol && last_row;
      if (eol) begin
         line_err_cur = line_err_next;
         foreach (line_err_next[i, c]) line_err_next[i][c] = 0;
         col_pos = 0;
         row_pos = last_row ? 0 : ((row_pos + 1) & 32'hFFFF);
      end else begin
         col_pos = x + 1;
      end
      return res;
   endfunction

   function automatic stim_row_type pixel_row(input logic [7:0] red, input logic [7:0] green,
                                              input logic [7:0] blue);
      stim_row_type row;
      row.kind = ROW_PIXEL;
      row.index = edd_pkg::CSR_LINE_WIDTH;
      row.value = '0;
      row.red = red;
      row.green = green;
      row.blue = blue;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] red, input logic [7:0] green,
                                                input logic [7:0] blue,
                                                input logic [7:0] red_code,
                                                input logic [7:0] green_code,
                                                input logic [7:0] blue_code, input logic eol,
                                                input logic eof);
      stim_row_type row;
      row = pixel_row(red, green, blue);
      row.typed = 1'b1;
      row.want = '{red_code, green_code, blue_code, eol, eof};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input edd_pkg::csr_index_type index,
                                            input logic [15:0] value);
      stim_row_type row;
      row = pixel_row('0, '0, '0);
      row.kind = ROW_CSR;
      row.index = index;
      row.value = value;
      return row;
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(240, 255));
         3: return 8'($urandom_range(0, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] random_kept_bits();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'd0;
      if (roll < 3) return 16'($urandom_range(9, 15));
      return 16'($urandom_range(1, 8));
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR: result %0d: %s", results_seen, what);
      error_count++;
   endtask

   task automatic write_csr(input edd_pkg::csr_index_type index, input logic [15:0] value);
      req_chan.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (index)
         edd_pkg::CSR_LINE_WIDTH: cfg_width = value & 16'hFFF;
         edd_pkg::CSR_FRAME_HEIGHT: cfg_height = value;
         edd_pkg::CSR_RED_BITS: cfg_bits[0] = value & 16'hF;
         edd_pkg::CSR_GREEN_BITS: cfg_bits[1] = value & 16'hF;
         edd_pkg::CSR_BLUE_BITS: cfg_bits[2] = value & 16'hF;
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input bit typed,
                             input dither_out_type want);
      dither_out_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.red_in <= red;
      req_chan.green_in <= green;
      req_chan.blue_in <= blue;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      predicted = dither_pixel(red, green, blue);
      expected_codes.push_back(typed ? want : predicted);
      pixels_sent++;
   endtask

   task automatic check_result();
      dither_out_type got;
      dither_out_type want;
      got = '{rsp_chan.red_code, rsp_chan.green_code, rsp_chan.blue_code,
              rsp_chan.end_of_line, rsp_chan.end_of_frame};
      results_seen++;
      if (expected_codes.size() == 0) begin
         report_mismatch("response with no request outstanding");
         return;
      end
      want = expected_codes.pop_front();
      if (got.red_code !== want.red_code)
         report_mismatch($sformatf("red_code %0d, expected %0d", got.red_code, want.red_code));
      if (got.green_code !== want.green_code)
         report_mismatch($sformatf("green_code %0d, expected %0d", got.green_code,
                                   want.green_code));
      if (got.blue_code !== want.blue_code)
         report_mismatch($sformatf("blue_code %0d, expected %0d", got.blue_code, want.blue_code));
      if (got.end_of_line !== want.end_of_line)
         report_mismatch($sformatf("end_of_line %b, expected %b", got.end_of_line,
                                   want.end_of_line));
      if (got.end_of_frame !== want.end_of_frame)
         report_mismatch($sformatf("end_of_frame %b, expected %b", got.end_of_frame,
                                   want.end_of_frame));
      if (want.end_of_line) lines_seen++;
      if (want.end_of_frame) frames_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   initial begin
      #1_600_000;
      $display("Timeout with %0d results still outstanding.", expected_codes.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [15:0] width;
      logic [15:0] height;
      int roll;
      req_chan.valid = 1'b0;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      // Defaults after reset, then a width cut below the current column, out-of-range
      // register values, single-pixel frames and one kept bit per channel.
      stim_table.push_back(checked_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
      stim_table.push_back(checked_row(8'd255, 8'd255, 8'd255, 8'd31, 8'd63, 8'd31, 1'b0, 1'b0));
      stim_table.push_back(pixel_row(8'd128, 8'd64, 8'd7));
      stim_table.push_back(pixel_row(8'd1, 8'd254, 8'd127));
      stim_table.push_back(csr_row(edd_pkg::CSR_LINE_WIDTH, 16'd3));
      stim_table.push_back(csr_row(edd_pkg::CSR_FRAME_HEIGHT, 16'd2));
      stim_table.push_back(csr_row(edd_pkg::CSR_RED_BITS, 16'd0));
      stim_table.push_back(csr_row(edd_pkg::CSR_GREEN_BITS, 16'd15));
      stim_table.push_back(csr_row(edd_pkg::CSR_BLUE_BITS, 16'd1));
      stim_table.push_back(pixel_row(8'd200, 8'd100, 8'd50));
      stim_table.push_back(pixel_row(8'd255, 8'd0, 8'd255));
      stim_table.push_back(pixel_row(8'd127, 8'd128, 8'd1));
      stim_table.push_back(pixel_row(8'd0, 8'd255, 8'd0));
      stim_table.push_back(pixel_row(8'd85, 8'd170, 8'd85));
      stim_table.push_back(pixel_row(8'd255, 8'd255, 8'd255));
      stim_table.push_back(pixel_row(8'd3, 8'd7, 8'd15));
      stim_table.push_back(csr_row(edd_pkg::CSR_LINE_WIDTH, 16'd4095));
      stim_table.push_back(csr_row(edd_pkg::CSR_FRAME_HEIGHT, 16'd65535));
      stim_table.push_back(csr_row(edd_pkg::CSR_RED_BITS, 16'd8));
      stim_table.push_back(csr_row(edd_pkg::CSR_GREEN_BITS, 16'd8));
      stim_table.push_back(csr_row(edd_pkg::CSR_BLUE_BITS, 16'd8));
      stim_table.push_back(pixel_row(8'd240, 8'd15, 8'd90));
      stim_table.push_back(pixel_row(8'd9, 8'd250, 8'd128));
      stim_table.push_back(csr_row(edd_pkg::CSR_LINE_WIDTH, 16'd0));
      stim_table.push_back(csr_row(edd_pkg::CSR_FRAME_HEIGHT, 16'd0));
      stim_table.push_back(pixel_row(8'd0, 8'd0, 8'd0));
      stim_table.push_back(checked_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                       1'b1, 1'b1));
      stim_table.push_back(checked_row(8'd170, 8'd85, 8'd1, 8'd170, 8'd85, 8'd1, 1'b1, 1'b1));
      stim_table.push_back(csr_row(edd_pkg::CSR_LINE_WIDTH, 16'd2048));
      stim_table.push_back(csr_row(edd_pkg::CSR_FRAME_HEIGHT, 16'd1));
      stim_table.push_back(csr_row(edd_pkg::CSR_RED_BITS, 16'd1));
      stim_table.push_back(csr_row(edd_pkg::CSR_GREEN_BITS, 16'd1));
      stim_table.push_back(csr_row(edd_pkg::CSR_BLUE_BITS, 16'd1));
      stim_table.push_back(pixel_row(8'd127, 8'd128, 8'd255));
      stim_table.push_back(pixel_row(8'd255, 8'd0, 8'd128));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            write_csr(stim_table[i].index, stim_table[i].value);
            config_count++;
         end else begin
            send_pixel(stim_table[i].red, stim_table[i].green, stim_table[i].blue,
                       stim_table[i].typed, stim_table[i].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 74; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 74; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         roll = $urandom_range(0, 19);
         if (roll == 0) width = 16'd2048;
         else if (roll == 1) width = 16'd0;
         else if (roll < 4) width = 16'($urandom_range(17, 300));
         else width = 16'($urandom_range(1, 16));
         roll = $urandom_range(0, 19);
         if (roll == 0) height = 16'd65535;
         else if (roll == 1) height = 16'd0;
         else height = 16'($urandom_range(1, 6));
         write_csr(edd_pkg::CSR_LINE_WIDTH, width);
         write_csr(edd_pkg::CSR_FRAME_HEIGHT, height);
         write_csr(edd_pkg::CSR_RED_BITS, random_kept_bits());
         write_csr(edd_pkg::CSR_GREEN_BITS, random_kept_bits());
         write_csr(edd_pkg::CSR_BLUE_BITS, random_kept_bits());
         config_count++;
         repeat (PIXELS_PER_PHASE) begin
            send_pixel(random_level(), random_level(), random_level(), 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Dithered %0d pixels into %0d lines and %0d frames under %0d register settings.",
               pixels_sent, lines_seen, frames_seen, config_count);
      $display("Responses compared: %0d, mismatches: %0d.", results_seen, error_count);
      if (error_count == 0 && expected_codes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
